>>> rtl/rotation_matrix_to_quaternion_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotation matrix to quaternion converter
// Expects clk_i and rst_ni in the scope of use.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// Same-cycle implication
`define RMQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RMQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Widths, stage counts and payload types of the matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int unsigned DATA_WIDTH = 16;
  localparam int unsigned FRAC_BITS  = 14;
  localparam int unsigned ONE        = 1 << FRAC_BITS;

  // signed width of t and the pair sums, and unsigned width of their magnitude
  localparam int unsigned VAL_W  = DATA_WIDTH + 2;
  localparam int unsigned MAG_W  = DATA_WIDTH + 1;
  // square root of t * 2^FRAC_BITS
  localparam int unsigned ROOT_W = (MAG_W + FRAC_BITS + 1) / 2;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned REM_W  = ROOT_W + 1;
  // quotient bits kept before saturation, and dividend width
  localparam int unsigned Q_W    = DATA_WIDTH - 1;
  localparam int unsigned N_W    = MAG_W + FRAC_BITS;

  localparam int unsigned SQ_STEPS  = ROOT_W;
  localparam int unsigned DV_STAGES = Q_W + 1;
  // input, branch, root digits, divide prep and digits, output
  localparam int unsigned NSTG      = 2 + SQ_STEPS + DV_STAGES + 1;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] col0_row0;
    logic signed [DATA_WIDTH-1:0] col0_row1;
    logic signed [DATA_WIDTH-1:0] col0_row2;
    logic signed [DATA_WIDTH-1:0] col1_row0;
    logic signed [DATA_WIDTH-1:0] col1_row1;
    logic signed [DATA_WIDTH-1:0] col1_row2;
    logic signed [DATA_WIDTH-1:0] col2_row0;
    logic signed [DATA_WIDTH-1:0] col2_row1;
    logic signed [DATA_WIDTH-1:0] col2_row2;
  } mat_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic                      nonpos;
    logic [VAL_W-1:0]          t;
    logic [3:0][VAL_W-1:0]     v;
  } br_t;

  typedef struct packed {
    br_t               br;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic              neg;
    logic              ovf;
    logic [ROOT_W-1:0] rem;
    logic [Q_W-1:0]    low;
    logic [Q_W-1:0]    q;
  } lane_t;

  typedef struct packed {
    logic              nonpos;
    logic [ROOT_W-1:0] s;
    lane_t [3:0]       lane;
  } dv_t;

endpackage

>>> rtl/rmq_branch.sv
// ----------------------------------------------------------------------------
// rmq_branch
// Picks a trace combination from the diagonal entries and forms t and the three pair terms.
// ----------------------------------------------------------------------------
module rmq_branch (
  input  logic         clk_i,
  input  logic         en_i,
  input  rmq_pkg::mat_t mat_i,
  output rmq_pkg::br_t  br_o
);
  import rmq_pkg::*;

  localparam logic signed [VAL_W-1:0] OneV = VAL_W'(ONE);

  logic signed [VAL_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [VAL_W-1:0] t;
  logic signed [VAL_W-1:0] v0, v1, v2, v3;
  br_t br_d, br_q;

  assign m00 = VAL_W'(mat_i.col0_row0);
  assign m01 = VAL_W'(mat_i.col0_row1);
  assign m02 = VAL_W'(mat_i.col0_row2);
  assign m10 = VAL_W'(mat_i.col1_row0);
  assign m11 = VAL_W'(mat_i.col1_row1);
  assign m12 = VAL_W'(mat_i.col1_row2);
  assign m20 = VAL_W'(mat_i.col2_row0);
  assign m21 = VAL_W'(mat_i.col2_row1);
  assign m22 = VAL_W'(mat_i.col2_row2);

  always_comb begin
    if (m22 < 0) begin
      if (m00 > m11) begin
        t  = OneV + m00 - m11 - m22;
        v0 = m12 - m21; v1 = t; v2 = m01 + m10; v3 = m20 + m02;
      end else begin
        t  = OneV - m00 + m11 - m22;
        v0 = m20 - m02; v1 = m01 + m10; v2 = t; v3 = m12 + m21;
      end
    end else begin
      if (m00 < -m11) begin
        t  = OneV - m00 - m11 + m22;
        v0 = m01 - m10; v1 = m20 + m02; v2 = m12 + m21; v3 = t;
      end else begin
        t  = OneV + m00 + m11 + m22;
        v0 = t; v1 = m12 - m21; v2 = m20 - m02; v3 = m01 - m10;
      end
    end
    br_d.nonpos = t[VAL_W-1] | (t == '0);
    br_d.t      = t;
    br_d.v      = {v3, v2, v1, v0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) br_q <= br_d;
  end

  assign br_o = br_q;

endmodule

>>> rtl/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Digit-by-digit integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module rmq_sqrt (
  input  logic                           clk_i,
  input  logic [rmq_pkg::SQ_STEPS-1:0]   en_i,
  input  rmq_pkg::br_t                   br_i,
  output rmq_pkg::sq_t                   sq_o
);
  import rmq_pkg::*;

  function automatic sq_t sq_step(sq_t a);
    sq_t              r;
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    r     = a;
    cur   = {a.rem, a.rad[RAD_W-1 -: 2]};
    trial = {1'b0, a.root, 2'b01};
    r.rad = a.rad << 2;
    if (cur >= trial) begin
      r.rem  = REM_W'(cur - trial);
      r.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = REM_W'(cur);
      r.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  sq_t init;
  sq_t stage_q [SQ_STEPS];

  always_comb begin
    init.br   = br_i;
    init.rad  = RAD_W'({br_i.t[MAG_W-1:0], {FRAC_BITS{1'b0}}});
    init.rem  = '0;
    init.root = '0;
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en_i[k]) stage_q[k] <= sq_step(init);
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en_i[k]) stage_q[k] <= sq_step(stage_q[k-1]);
      end
    end
  end

  assign sq_o = stage_q[SQ_STEPS-1];

endmodule

>>> rtl/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Four-lane restoring divider: rounded V * 2^(FRAC_BITS-1) / s, one bit per stage.
// ----------------------------------------------------------------------------
module rmq_div (
  input  logic                           clk_i,
  input  logic [rmq_pkg::DV_STAGES-1:0]  en_i,
  input  rmq_pkg::sq_t                   sq_i,
  output rmq_pkg::dv_t                   dv_o
);
  import rmq_pkg::*;

  function automatic lane_t lane_prep(logic [VAL_W-1:0] v, logic [ROOT_W-1:0] s);
    lane_t            r;
    logic [VAL_W-1:0] a;
    logic [N_W-1:0]   n;
    r.neg = v[VAL_W-1];
    a     = r.neg ? (~v + 1'b1) : v;
    n     = N_W'({a[MAG_W-1:0], {(FRAC_BITS-1){1'b0}}}) + N_W'(s >> 1);
    r.rem = n[N_W-1:Q_W];
    r.ovf = (n[N_W-1:Q_W] >= s);
    r.low = n[Q_W-1:0];
    r.q   = '0;
    return r;
  endfunction

  function automatic lane_t lane_step(lane_t a, logic [ROOT_W-1:0] s);
    lane_t           r;
    logic [ROOT_W:0] cur;
    r     = a;
    cur   = {a.rem, a.low[Q_W-1]};
    r.low = a.low << 1;
    if (cur >= {1'b0, s}) begin
      r.rem = ROOT_W'(cur - {1'b0, s});
      r.q   = {a.q[Q_W-2:0], 1'b1};
    end else begin
      r.rem = ROOT_W'(cur);
      r.q   = {a.q[Q_W-2:0], 1'b0};
    end
    return r;
  endfunction

  dv_t stage_q [DV_STAGES];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      stage_q[0].nonpos <= sq_i.br.nonpos;
      stage_q[0].s      <= sq_i.root;
      for (int l = 0; l < 4; l++) begin
        stage_q[0].lane[l] <= lane_prep(sq_i.br.v[l], sq_i.root);
      end
    end
  end

  for (genvar k = 1; k < DV_STAGES; k++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        stage_q[k].nonpos <= stage_q[k-1].nonpos;
        stage_q[k].s      <= stage_q[k-1].s;
        for (int l = 0; l < 4; l++) begin
          stage_q[k].lane[l] <= lane_step(stage_q[k-1].lane[l], stage_q[k-1].s);
        end
      end
    end
  end

  assign dv_o = stage_q[DV_STAGES-1];

endmodule

>>> rtl/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a column-major Q1.14 rotation matrix to a saturated unit quaternion.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_ready_o | in_data_i  (mat_t, nine entries)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (quat_t, w x y z)
//
//  From input transaction to output valid the data passes the NSTG stages:
//  input register, branch select, 16 square root digit stages, divide prep,
//  15 quotient bit stages, and the saturating output register.
//  One transaction per cycle is sustained while out_ready_i stays high; every stage holds a valid bit.
//  A stage advances when it is empty or the stage after it advances, so a
//  stalled output fills bubbles upstream before in_ready_o drops.
//  Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_defines.svh"

module rotation_matrix_to_quaternion (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rmq_pkg::mat_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rmq_pkg::quat_t out_data_o
);
  import rmq_pkg::*;

  localparam logic signed [DATA_WIDTH-1:0] OneS = DATA_WIDTH'(ONE);

  // stage indices
  localparam int unsigned StBr  = 1;
  localparam int unsigned StSq  = 2;
  localparam int unsigned StDv  = StSq + SQ_STEPS;
  localparam int unsigned StOut = NSTG - 1;

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] en;
  mat_t            mat_q;
  br_t             br;
  sq_t             sq;
  dv_t             dv;
  quat_t           out_d, out_q;

  // Advance a stage when it is empty or its successor advances.
  always_comb begin
    en[StOut] = !vld_q[StOut] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Capture the matrix.
  always_ff @(posedge clk_i) begin
    if (en[0]) mat_q <= in_data_i;
  end

  rmq_branch u_branch (
    .clk_i (clk_i),
    .en_i  (en[StBr]),
    .mat_i (mat_q),
    .br_o  (br)
  );

  rmq_sqrt u_sqrt (
    .clk_i (clk_i),
    .en_i  (en[StDv-1:StSq]),
    .br_i  (br),
    .sq_o  (sq)
  );

  rmq_div u_div (
    .clk_i (clk_i),
    .en_i  (en[StOut-1:StDv]),
    .sq_i  (sq),
    .dv_o  (dv)
  );

  // Clamp each quotient to 1.0, restore the sign, zero out when t <= 0.
  function automatic logic [DATA_WIDTH-1:0] finish(lane_t l, logic nonpos);
    logic [DATA_WIDTH-1:0] mag;
    mag = (l.ovf || ({1'b0, l.q} > DATA_WIDTH'(ONE))) ? DATA_WIDTH'(ONE)
                                                       : {1'b0, l.q};
    if (nonpos) return '0;
    return l.neg ? (~mag + 1'b1) : mag;
  endfunction

  always_comb begin
    out_d.quat_w = finish(dv.lane[0], dv.nonpos);
    out_d.quat_x = finish(dv.lane[1], dv.nonpos);
    out_d.quat_y = finish(dv.lane[2], dv.nonpos);
    out_d.quat_z = finish(dv.lane[3], dv.nonpos);
  end

  always_ff @(posedge clk_i) begin
    if (en[StOut]) out_q <= out_d;
  end

  assign out_valid_o = vld_q[StOut];
  assign out_data_o  = out_q;

  // Input backpressure only when the whole pipeline is full and held.
  `RMQ_ASSERT_IMP(a_stall_full, !in_ready_o, out_valid_o && !out_ready_i && (&vld_q), "in_ready_o low without full stalled pipeline")

  // Results never exceed unit magnitude.
  `RMQ_ASSERT_IMP(a_out_range, out_valid_o, out_data_o.quat_w <= OneS && out_data_o.quat_w >= -OneS && out_data_o.quat_x <= OneS && out_data_o.quat_x >= -OneS && out_data_o.quat_y <= OneS && out_data_o.quat_y >= -OneS && out_data_o.quat_z <= OneS && out_data_o.quat_z >= -OneS, "quaternion component out of range")

  // A taken result with an empty stage behind it leaves the output empty.
  `RMQ_ASSERT_NXT(a_drain, out_valid_o && out_ready_i && !vld_q[StOut-1], !out_valid_o, "output repeated after transaction")

endmodule
